/* rtl/fcull_pkg.sv */
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants for the frustum cull test block.
// ----------------------------------------------------------------------------
package fcull_pkg;

  // Payload field widths
  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned RADIUS_W        = 31;
  localparam int unsigned MASK_W          = 7;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned PLANE_W         = 3;
  localparam int unsigned COEF_W          = 2;

  // Plane store geometry
  localparam int unsigned NUM_PLANES      = 6;
  localparam int unsigned COEF_PER_PLANE  = 4;
  localparam int unsigned STORE_DEPTH     = NUM_PLANES * COEF_PER_PLANE;
  localparam int unsigned ADDR_W          = PLANE_W + COEF_W;

  // Q16.16 scaling of the plane offset and the radius
  localparam int unsigned Q_SHIFT         = 16;

  // Default coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Last sequencer step index per plane
  localparam int unsigned STEP_W          = 3;
  localparam logic [STEP_W-1:0] LAST_STEP_SIMPLE = STEP_W'(3);
  localparam logic [STEP_W-1:0] LAST_STEP_BOX    = STEP_W'(6);

  // Mask codes
  localparam logic [MASK_W-1:0] MASK_OUTSIDE    = MASK_W'(0);
  localparam logic [MASK_W-1:0] MASK_INSIDE     = MASK_W'(1);
  localparam logic [MASK_W-1:0] FIRST_PLANE_BIT = MASK_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_SPHERE = 2'd2,
    KIND_BOX    = 2'd3
  } kind_e;

  typedef enum logic [COEF_W-1:0] {
    COEF_NX = 2'd0,
    COEF_NY = 2'd1,
    COEF_NZ = 2'd2,
    COEF_D  = 2'd3
  } coef_e;

  // What one multiply-accumulate beat does
  typedef enum logic [1:0] {
    OP_POS = 2'd0,  // n * position, into the main accumulator
    OP_PV  = 2'd1,  // n * positive-vertex coordinate
    OP_NV  = 2'd2,  // n * negative-vertex coordinate
    OP_OFS = 2'd3   // d << 16, into both accumulators
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  typedef struct packed {
    logic               valid;
    op_e                op;
    coef_e              coef;
    logic               first;
    logic               last;
    logic [PLANE_W-1:0] plane;
  } op_t;

endpackage

/* rtl/fcull_ram.sv */
// ----------------------------------------------------------------------------
// fcull_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcull_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fcull_seq.sv */
// ----------------------------------------------------------------------------
// fcull_seq
// Walks the selected planes and issues one multiply-accumulate beat a cycle.
// ----------------------------------------------------------------------------
module fcull_seq
  import fcull_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  flush_i,
  input  kind_e                 kind_i,
  input  logic [NUM_PLANES-1:0] planes_i,
  output op_t                   op_o,
  output logic [ADDR_W-1:0]     raddr_o,
  output logic                  idle_o
);

  logic [NUM_PLANES-1:0] todo_q, todo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  kind_e                 kind_q, kind_d;
  logic [PLANE_W-1:0]    plane;
  logic                  last;

  // lowest pending plane
  always_comb begin
    plane = '0;
    for (int i = NUM_PLANES - 1; i >= 0; i--) begin
      if (todo_q[i]) begin
        plane = PLANE_W'(i);
      end
    end
  end

  // step decode
  always_comb begin
    op_o       = '0;
    op_o.valid = (todo_q != '0);
    op_o.plane = plane;
    if (kind_q == KIND_BOX) begin
      last = (step_q == LAST_STEP_BOX);
      if (last) begin
        op_o.op   = OP_OFS;
        op_o.coef = COEF_D;
      end else begin
        op_o.op   = step_q[0] ? OP_NV : OP_PV;
        op_o.coef = coef_e'(step_q[STEP_W-1:1]);
      end
    end else begin
      last = (step_q == LAST_STEP_SIMPLE);
      if (last) begin
        op_o.op   = OP_OFS;
        op_o.coef = COEF_D;
      end else begin
        op_o.op   = OP_POS;
        op_o.coef = coef_e'(step_q[COEF_W-1:0]);
      end
    end
    op_o.last  = last;
    op_o.first = (op_o.coef == COEF_NX);
  end

  assign raddr_o = {plane, op_o.coef};
  assign idle_o  = (todo_q == '0);

  always_comb begin
    todo_d = todo_q;
    step_d = step_q;
    kind_d = kind_q;
    priority if (flush_i) begin
      todo_d = '0;
      step_d = '0;
    end else if (start_i) begin
      todo_d = planes_i;
      step_d = '0;
      kind_d = kind_i;
    end else if (todo_q != '0) begin
      if (last) begin
        todo_d = todo_q & (todo_q - NUM_PLANES'(1));
        step_d = '0;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      todo_q <= '0;
      step_q <= '0;
      kind_q <= KIND_POINT;
    end else begin
      todo_q <= todo_d;
      step_q <= step_d;
      kind_q <= kind_d;
    end
  end

endmodule

/* rtl/fcull_dot.sv */
// ----------------------------------------------------------------------------
// fcull_dot
// Shared multiply-accumulate unit: one coefficient times one coordinate per
// beat, summed into the plane distance at full width.
// ----------------------------------------------------------------------------
module fcull_dot
  import fcull_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned ACC_W      = 2 * COORD_WIDTH + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          flush_i,
  input  op_t                           op_i,
  input  logic signed [COORD_WIDTH-1:0] coef_i,
  input  logic signed [COORD_WIDTH-1:0] min_x_i,
  input  logic signed [COORD_WIDTH-1:0] min_y_i,
  input  logic signed [COORD_WIDTH-1:0] min_z_i,
  input  logic signed [COORD_WIDTH-1:0] max_x_i,
  input  logic signed [COORD_WIDTH-1:0] max_y_i,
  input  logic signed [COORD_WIDTH-1:0] max_z_i,
  output logic signed [ACC_W-1:0]       acc_pv_o,
  output logic signed [ACC_W-1:0]       acc_nv_o,
  output logic                          eval_o,
  output logic [PLANE_W-1:0]            eval_plane_o,
  output logic                          busy_o
);

  localparam int unsigned PROD_W = 2 * COORD_WIDTH;

  op_t                           op_a_q, op_b_q;
  logic signed [COORD_WIDTH-1:0] lo_c, hi_c, m_c;
  logic                          n_pos;
  logic signed [PROD_W-1:0]      term_d, term_q;
  logic signed [ACC_W-1:0]       term_ext;
  logic signed [ACC_W-1:0]       acc_pv_d, acc_pv_q, acc_nv_d, acc_nv_q;
  logic                          eval_q;
  logic [PLANE_W-1:0]            eval_plane_q;

  // stage B: coefficient from RAM times selected coordinate
  always_comb begin
    unique case (op_a_q.coef)
      COEF_NX: begin lo_c = min_x_i; hi_c = max_x_i; end
      COEF_NY: begin lo_c = min_y_i; hi_c = max_y_i; end
      COEF_NZ: begin lo_c = min_z_i; hi_c = max_z_i; end
      COEF_D:  begin lo_c = min_x_i; hi_c = max_x_i; end
    endcase
    n_pos = !coef_i[COORD_WIDTH-1] && (coef_i != '0);
    unique case (op_a_q.op)
      OP_POS:  m_c = lo_c;
      OP_PV:   m_c = n_pos ? hi_c : lo_c;
      OP_NV:   m_c = n_pos ? lo_c : hi_c;
      OP_OFS:  m_c = lo_c;
    endcase
    if (op_a_q.op == OP_OFS) begin
      term_d = PROD_W'(coef_i) <<< Q_SHIFT;
    end else begin
      term_d = coef_i * m_c;
    end
  end

  // stage C: accumulate
  always_comb begin
    term_ext = ACC_W'(term_q);
    acc_pv_d = acc_pv_q;
    acc_nv_d = acc_nv_q;
    if (op_b_q.valid) begin
      unique case (op_b_q.op)
        OP_POS, OP_PV: acc_pv_d = op_b_q.first ? term_ext : acc_pv_q + term_ext;
        OP_NV:         acc_nv_d = op_b_q.first ? term_ext : acc_nv_q + term_ext;
        OP_OFS: begin
          acc_pv_d = acc_pv_q + term_ext;
          acc_nv_d = acc_nv_q + term_ext;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_a_q <= '0;
      op_b_q <= '0;
      eval_q <= 1'b0;
    end else if (flush_i) begin
      op_a_q <= '0;
      op_b_q <= '0;
      eval_q <= 1'b0;
    end else begin
      op_a_q <= op_i;
      op_b_q <= op_a_q;
      eval_q <= op_b_q.valid && op_b_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q       <= term_d;
    acc_pv_q     <= acc_pv_d;
    acc_nv_q     <= acc_nv_d;
    eval_plane_q <= op_b_q.plane;
  end

  assign acc_pv_o     = acc_pv_q;
  assign acc_nv_o     = acc_nv_q;
  assign eval_o       = eval_q;
  assign eval_plane_o = eval_plane_q;
  assign busy_o       = op_a_q.valid || op_b_q.valid || eval_q;

endmodule

/* rtl/frustum_cull_test.sv */
// ----------------------------------------------------------------------------
// frustum_cull_test
// Point, sphere and box classification against six stored frustum planes.
// ----------------------------------------------------------------------------
// Load beats (kind 0) write one plane coefficient into a 24-word store and
// return nothing; loads to plane 6 or 7 are dropped. Test beats classify a
// point, sphere or axis-aligned box against the planes flagged in mask_in
// and return one mask_out beat. A mask_in of 0 or 1 comes straight back.
// Coordinates and coefficients are signed Q16.16 and the radius is unsigned
// Q15.16; distances n.p + d are summed exactly and compared at full width.
// A test runs one shared multiplier over the plane store, one beat per
// cycle: 4 beats per selected plane for point and sphere, 7 for a box (both
// box corners share the multiplier), then the pipeline drains and the result
// goes to the output register. A test that falls outside a plane stops at
// once. in_stall_o is high for the whole test; the output register holds a
// finished beat so the next item may be taken while that beat waits. Read
// planes only after all their coefficients are loaded; the store has no
// reset.
// ----------------------------------------------------------------------------
module frustum_cull_test
  import fcull_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [PLANE_W-1:0]  plane_index_i,
  input  logic [COEF_W-1:0]   coef_index_i,
  input  logic [FIELD_W-1:0]  coef_value_i,
  input  logic [FIELD_W-1:0]  pos_x_i,
  input  logic [FIELD_W-1:0]  pos_y_i,
  input  logic [FIELD_W-1:0]  pos_z_i,
  input  logic [FIELD_W-1:0]  max_x_i,
  input  logic [FIELD_W-1:0]  max_y_i,
  input  logic [FIELD_W-1:0]  max_z_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic [MASK_W-1:0]   mask_in_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MASK_W-1:0]   mask_out_o
);

  localparam int unsigned ACC_W = 2 * COORD_WIDTH + 3;
  localparam int unsigned R_W   = COORD_WIDTH - 1;

  // signed zero so distance compares stay signed
  localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;

  state_e                        state_q, state_d;
  kind_e                         kind_in;
  kind_e                         kind_q;
  logic                          in_acc;

  logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q, qx_q, qy_q, qz_q;
  logic [R_W-1:0]                radius_q;
  logic [MASK_W-1:0]             mask_q, mask_d;
  logic [MASK_W-1:0]             result_q, result_d;
  logic                          out_valid_q, out_valid_d;
  logic [MASK_W-1:0]             mask_out_q;
  logic                          capture, out_load;

  // plane store
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [COORD_WIDTH-1:0]        ram_rdata;

  // sequencer / MAC
  op_t                           seq_op;
  logic                          seq_start, seq_idle, flush;
  logic signed [ACC_W-1:0]       acc_pv, acc_nv;
  logic                          eval, dot_busy;
  logic [PLANE_W-1:0]            eval_plane;

  // plane test
  logic signed [ACC_W-1:0]       r_ext;
  logic                          outside, bit_set;
  logic [MASK_W-1:0]             plane_bit;

  assign kind_in    = kind_e'(kind_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ram_we = in_acc && (kind_in == KIND_LOAD) &&
                  (plane_index_i < PLANE_W'(NUM_PLANES));

  fcull_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({plane_index_i, coef_index_i}),
    .wdata_i (coef_value_i[COORD_WIDTH-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fcull_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seq_start),
    .flush_i  (flush),
    .kind_i   (kind_in),
    .planes_i (mask_in_i[MASK_W-1:1]),
    .op_o     (seq_op),
    .raddr_o  (ram_raddr),
    .idle_o   (seq_idle)
  );

  fcull_dot #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (flush),
    .op_i         (seq_op),
    .coef_i       (ram_rdata),
    .min_x_i      (px_q),
    .min_y_i      (py_q),
    .min_z_i      (pz_q),
    .max_x_i      (qx_q),
    .max_y_i      (qy_q),
    .max_z_i      (qz_q),
    .acc_pv_o     (acc_pv),
    .acc_nv_o     (acc_nv),
    .eval_o       (eval),
    .eval_plane_o (eval_plane),
    .busy_o       (dot_busy)
  );

  // Per-plane decision on the finished distance(s).
  // Sphere: outside at v <= -r, intersecting while v < r.
  // Box: outside if positive vertex <= 0, intersecting unless negative
  // vertex > 0.
  assign r_ext     = signed'({{(ACC_W - R_W - Q_SHIFT){1'b0}}, radius_q, {Q_SHIFT{1'b0}}});
  assign plane_bit = FIRST_PLANE_BIT << eval_plane;

  always_comb begin
    unique case (kind_q)
      KIND_SPHERE: begin
        outside = (acc_pv <= -r_ext);
        bit_set = (acc_pv < r_ext);
      end
      KIND_BOX: begin
        outside = (acc_pv <= ACC_ZERO);
        bit_set = !(acc_nv > ACC_ZERO);
      end
      default: begin
        outside = (acc_pv < ACC_ZERO);
        bit_set = 1'b0;
      end
    endcase
  end

  // Control
  always_comb begin
    state_d   = state_q;
    mask_d    = mask_q;
    result_d  = result_q;
    seq_start = 1'b0;
    flush     = 1'b0;
    capture   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_in != KIND_LOAD)) begin
          if (mask_in_i <= MASK_INSIDE) begin
            result_d = mask_in_i;
            state_d  = ST_FINISH;
          end else begin
            capture   = 1'b1;
            seq_start = 1'b1;
            mask_d    = mask_in_i;
            state_d   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        priority if (eval && outside) begin
          flush    = 1'b1;
          result_d = MASK_OUTSIDE;
          state_d  = ST_FINISH;
        end else if (eval) begin
          if (kind_q != KIND_POINT) begin
            mask_d = bit_set ? (mask_q | plane_bit) : (mask_q & ~plane_bit);
          end
        end else if (seq_idle && !dot_busy) begin
          priority if (kind_q == KIND_POINT) begin
            result_d = MASK_INSIDE;
          end else if (mask_q == MASK_OUTSIDE) begin
            result_d = MASK_INSIDE;
          end else begin
            result_d = mask_q;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (capture) begin
      kind_q   <= kind_in;
      px_q     <= pos_x_i[COORD_WIDTH-1:0];
      py_q     <= pos_y_i[COORD_WIDTH-1:0];
      pz_q     <= pos_z_i[COORD_WIDTH-1:0];
      qx_q     <= max_x_i[COORD_WIDTH-1:0];
      qy_q     <= max_y_i[COORD_WIDTH-1:0];
      qz_q     <= max_z_i[COORD_WIDTH-1:0];
      radius_q <= radius_i[R_W-1:0];
    end
    mask_q   <= mask_d;
    result_q <= result_d;
    if (out_load) begin
      mask_out_q <= result_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mask_out_o  = mask_out_q;

  // Assertions
  // the sequencer only issues beats while a test runs
  a_seq_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> seq_idle)
    else $error("sequencer active outside RUN");

  // MAC pipeline is drained or flushed whenever the block leaves RUN
  a_dot_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !dot_busy)
    else $error("MAC pipeline busy outside RUN");

  // a new output beat is only launched from FINISH
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_FINISH))
    else $error("output beat without FINISH");

endmodule
